### hdl/pesc_pkg.sv
// ---------------------------------------------------------------------------
// PETSCII escape encoder package
// Word types, character constants, the escape name table and the
// per-character conversion that the front and back ends share.
// ---------------------------------------------------------------------------
`default_nettype none

package pesc_pkg;

    // Input word: one ASCII character and the end-of-text mark.
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_text;
    } t_in_word;

    // Output word: one PETSCII byte and the last-of-run mark.
    typedef struct packed {
        logic [7:0] byte_out;
        logic       last_of_run;
    } t_out_word;

    // Command handed from the front end to the back end. A flush command
    // emits a space for the brace, the collected name converted, then code.
    typedef struct packed {
        logic       is_flush;
        logic [7:0] code;
    } t_cmd;

    typedef enum logic [1:0] {
        SM_NORMAL  = 2'd0,
        SM_COLLECT = 2'd1,
        SM_LITERAL = 2'd2
    } t_scan_mode;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_NAME,
        BK_CLOSE
    } t_back_state;

    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_AT     = 8'h40;
    localparam logic [7:0] BYTE_SPACE  = 8'h20;
    localparam logic [7:0] BYTE_NUL    = 8'h00;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // Longest name in the table, in characters.
    localparam int NAME_W    = 10;
    localparam int NUM_NAMES = 48;

    // Text is right-justified: the last character sits in the low byte.
    typedef struct packed {
        logic [NAME_W*8-1:0] text;
        logic [3:0]          len;
        logic [7:0]          code;
    } t_name_entry;

    localparam t_name_entry NAME_TABLE [NUM_NAMES] = '{
        '{"black",      4'd5,  8'h90}, '{"white",      4'd5,  8'h05},
        '{"red",        4'd3,  8'h1C}, '{"cyan",       4'd4,  8'h9F},
        '{"magenta",    4'd7,  8'h9C}, '{"purple",     4'd6,  8'h9C},
        '{"green",      4'd5,  8'h1E}, '{"blue",       4'd4,  8'h1F},
        '{"yellow",     4'd6,  8'h9E}, '{"home",       4'd4,  8'h13},
        '{"clear",      4'd5,  8'h93}, '{"esc",        4'd3,  8'h27},
        '{"back",       4'd4,  8'h08}, '{"delete",     4'd6,  8'h14},
        '{"del",        4'd3,  8'h14}, '{"insert",     4'd6,  8'h94},
        '{"ins",        4'd3,  8'h94}, '{"reverse",    4'd7,  8'h12},
        '{"rev",        4'd3,  8'h12}, '{"under",      4'd5,  8'h82},
        '{"underline",  4'd9,  8'h82}, '{"off",        4'd3,  8'h81},
        '{"bell",       4'd4,  8'h07}, '{"up",         4'd2,  8'h91},
        '{"down",       4'd4,  8'h0A}, '{"left",       4'd4,  8'h9D},
        '{"right",      4'd5,  8'h1D}, '{"tab",        4'd3,  8'h09},
        '{"crsr-up",    4'd7,  8'h91}, '{"crsr-down",  4'd9,  8'h0A},
        '{"crsr-left",  4'd9,  8'h9D}, '{"crsr-right", 4'd10, 8'h1D},
        '{"f1",         4'd2,  8'h85}, '{"f2",         4'd2,  8'h89},
        '{"f3",         4'd2,  8'h86}, '{"f4",         4'd2,  8'h8A},
        '{"f5",         4'd2,  8'h87}, '{"f6",         4'd2,  8'h8B},
        '{"f7",         4'd2,  8'h88}, '{"f8",         4'd2,  8'h8C},
        '{"shift-f1",   4'd8,  8'h85}, '{"shift-f2",   4'd8,  8'h89},
        '{"shift-f3",   4'd8,  8'h86}, '{"shift-f4",   4'd8,  8'h8A},
        '{"shift-f5",   4'd8,  8'h87}, '{"shift-f6",   4'd8,  8'h8B},
        '{"shift-f7",   4'd8,  8'h88}, '{"shift-f8",   4'd8,  8'h8C}
    };

    // Character at position pos (0 = first) of a table name.
    function automatic logic [7:0] name_char(input t_name_entry e, input int unsigned pos);
        logic [NAME_W*8-1:0] t;
        t = '0;
        if (pos < e.len) begin
            t = e.text >> (8 * (int'(e.len) - 1 - int'(pos)));
        end
        return t[7:0];
    endfunction

    // One ASCII character to PETSCII.
    function automatic logic [7:0] petscii_conv(input logic [7:0] c);
        logic [7:0] r;
        r = BYTE_SPACE;
        if (c inside {[8'h20:8'h3F], [8'h41:8'h5F]}) begin
            r = c;
        end else if (c inside {[8'h61:8'h7A]}) begin
            r = c - CASE_OFFSET;
        end else if (c == CHAR_AT) begin
            r = BYTE_NUL;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/petscii_escape_encoder_core.sv
// ---------------------------------------------------------------------------
// PETSCII escape encoder core
// Converts an ASCII character stream to PETSCII bytes, replacing brace
// escapes such as {red} or {clear} with their single control codes.
// ---------------------------------------------------------------------------
// Path: the first byte of a word is registered in the command queue and then in the
// output word; a word that only extends an escape name gives none.
// Throughput: one word per cycle while the two-entry command queue has room. The
// back end emits one byte per cycle while the output is ready, so a flush of n
// collected characters gives n + 2 bytes (at most MAX_NAME_LEN + 2) and can hold off the input.
// Reset: synchronous, active low; clears mode, count, queue, back-end state and output valid only.
`default_nettype none

module petscii_escape_encoder_core #(
    parameter int MAX_NAME_LEN = 10
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  pesc_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output pesc_pkg::t_out_word  o_out_word
);
    import pesc_pkg::*;

    localparam int CNT_W = $clog2(MAX_NAME_LEN + 1);
    localparam int BUF_W = MAX_NAME_LEN * 8;
    localparam int CMD_W = $bits(t_cmd);
    localparam int Q_W   = CMD_W + CNT_W + BUF_W;

    // Front end to queue.
    logic             push;
    logic             q_full;
    t_cmd             f_cmd;
    logic [CNT_W-1:0] f_count;
    logic [BUF_W-1:0] f_buf;

    // Queue to back end.
    logic             pop;
    logic             q_valid;
    logic [Q_W-1:0]   q_head;
    t_cmd             b_cmd;
    logic [CNT_W-1:0] b_count;
    logic [BUF_W-1:0] b_buf;

    // The front end classifies each word and updates the scan state in the
    // cycle it is accepted. Any word that yields bytes becomes one command:
    // either a single finished byte, or a flush that carries a snapshot of
    // the collected name so the front end can start a new name at once.
    pesc_front #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (f_cmd),
        .o_cmd_count (f_count),
        .o_cmd_buf   (f_buf)
    );

    // Two commands of slack let the front end keep taking words while the
    // back end stalls on the output or drains a flush.
    pesc_queue #(
        .W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cmd, f_count, f_buf}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    assign b_cmd   = t_cmd'(q_head[Q_W-1 -: CMD_W]);
    assign b_count = q_head[BUF_W +: CNT_W];
    assign b_buf   = q_head[BUF_W-1:0];

    // The back end sequences each command into bytes: a single byte, or a
    // space for the brace, the name characters converted, and the closing
    // byte, which carries the last-of-run mark.
    pesc_back #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (b_cmd),
        .i_q_count   (b_count),
        .i_q_buf     (b_buf),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

### hdl/pesc_front.sv
// ---------------------------------------------------------------------------
// PETSCII escape encoder front end
// Accepts input words, tracks the brace scan mode, collects escape names
// and issues one command per word that produces output.
// ---------------------------------------------------------------------------
`default_nettype none

module pesc_front #(
    parameter int MAX_NAME_LEN = 10,
    localparam int CNT_W = $clog2(MAX_NAME_LEN + 1),
    localparam int IDX_W = $clog2(MAX_NAME_LEN)
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  pesc_pkg::t_in_word         i_in_word,
    input  wire                        i_q_full,
    output logic                       o_push,
    output pesc_pkg::t_cmd             o_cmd,
    output logic [CNT_W-1:0]           o_cmd_count,
    output logic [MAX_NAME_LEN*8-1:0]  o_cmd_buf
);
    import pesc_pkg::*;

    t_scan_mode       r_mode, n_mode;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_buf [MAX_NAME_LEN];

    logic       accept;
    logic [7:0] c;
    logic       eot;
    logic       is_open;
    logic       is_close;
    logic       full_name;
    logic       collect_wr;
    logic [7:0] name_code;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign c          = i_in_word.char_in;
    assign eot        = i_in_word.end_of_text;
    assign is_open    = (c == CHAR_LBRACE);
    assign is_close   = (c == CHAR_RBRACE);
    assign full_name  = (r_count >= CNT_W'(MAX_NAME_LEN));
    assign collect_wr = accept && (r_mode == SM_COLLECT) && !is_close && !full_name && !eot;

    // Name lookup against the fixed table; zero means no match.
    always_comb begin
        logic hit;
        name_code = '0;
        for (int e = 0; e < NUM_NAMES; e++) begin
            hit = (r_count == CNT_W'(NAME_TABLE[e].len));
            for (int i = 0; i < NAME_W; i++) begin
                if ((i < int'(NAME_TABLE[e].len)) &&
                    (r_buf[i] != name_char(NAME_TABLE[e], i))) begin
                    hit = 1'b0;
                end
            end
            if (hit && (name_code == '0)) begin
                name_code = NAME_TABLE[e].code;
            end
        end
    end

    // Next scan mode and fill count.
    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        if (accept) begin
            case (r_mode)
                SM_COLLECT: begin
                    if (is_close) begin
                        n_mode  = SM_NORMAL;
                        n_count = '0;
                    end else if (full_name) begin
                        n_mode  = SM_LITERAL;
                        n_count = '0;
                    end else if (eot) begin
                        n_count = '0;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                SM_LITERAL: begin
                    if (is_close) begin
                        n_mode = SM_NORMAL;
                    end
                end
                SM_NORMAL: begin
                    if (is_open && !eot) begin
                        n_mode  = SM_COLLECT;
                        n_count = '0;
                    end
                end
                default: begin
                    n_mode = SM_NORMAL;
                end
            endcase
            if (eot) begin
                n_mode  = SM_NORMAL;
                n_count = '0;
            end
        end
    end

    // Command issue.
    always_comb begin
        o_push        = 1'b0;
        o_cmd.is_flush = 1'b0;
        o_cmd.code    = petscii_conv(c);
        if (accept) begin
            case (r_mode)
                SM_COLLECT: begin
                    if (is_close) begin
                        o_push = 1'b1;
                        if (name_code != '0) begin
                            o_cmd.code = name_code;
                        end else begin
                            o_cmd.is_flush = 1'b1;
                            o_cmd.code     = BYTE_SPACE;
                        end
                    end else if (full_name || eot) begin
                        o_push         = 1'b1;
                        o_cmd.is_flush = 1'b1;
                    end
                end
                SM_LITERAL: begin
                    o_push = 1'b1;
                end
                SM_NORMAL: begin
                    o_push = !(is_open && !eot);
                end
                default: begin
                    o_push = 1'b1;
                end
            endcase
        end
    end

    assign o_cmd_count = r_count;

    always_comb begin
        for (int k = 0; k < MAX_NAME_LEN; k++) begin
            o_cmd_buf[8*k +: 8] = r_buf[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= SM_NORMAL;
            r_count <= '0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (collect_wr) begin
            r_buf[r_count[IDX_W-1:0]] <= c;
        end
    end

endmodule

`default_nettype wire

### hdl/pesc_queue.sv
// ---------------------------------------------------------------------------
// PETSCII escape encoder command queue
// Two-entry first-in first-out buffer between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module pesc_queue #(
    parameter int W = 8
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  wire  [W-1:0] i_data,
    output logic         o_full,
    input  wire          i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_head
);
    logic [W-1:0] r_d0, r_d1;
    logic         r_v0, r_v1;

    assign o_full  = r_v1;
    assign o_valid = r_v0;
    assign o_head  = r_d0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (i_pop && i_push) begin
            r_v0 <= 1'b1;
        end else if (i_pop) begin
            r_v0 <= r_v1;
            r_v1 <= 1'b0;
        end else if (i_push) begin
            if (!r_v0) begin
                r_v0 <= 1'b1;
            end else begin
                r_v1 <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop && i_push) begin
            if (r_v1) begin
                r_d0 <= r_d1;
                r_d1 <= i_data;
            end else begin
                r_d0 <= i_data;
            end
        end else if (i_pop) begin
            r_d0 <= r_d1;
        end else if (i_push) begin
            if (!r_v0) begin
                r_d0 <= i_data;
            end else begin
                r_d1 <= i_data;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/pesc_back.sv
// ---------------------------------------------------------------------------
// PETSCII escape encoder back end
// Executes queued commands and drives the registered output word, one
// byte per cycle while the output is ready.
// ---------------------------------------------------------------------------
`default_nettype none

module pesc_back #(
    parameter int MAX_NAME_LEN = 10,
    localparam int CNT_W = $clog2(MAX_NAME_LEN + 1),
    localparam int IDX_W = $clog2(MAX_NAME_LEN)
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_q_valid,
    input  pesc_pkg::t_cmd             i_q_cmd,
    input  wire  [CNT_W-1:0]           i_q_count,
    input  wire  [MAX_NAME_LEN*8-1:0]  i_q_buf,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output pesc_pkg::t_out_word        o_out_word
);
    import pesc_pkg::*;

    t_back_state      r_state, n_state;
    logic [7:0]       r_tail;
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_buf [MAX_NAME_LEN];
    logic [IDX_W-1:0] r_pos;
    logic             r_out_valid;
    t_out_word        r_out_word;

    logic      can_emit;
    logic      emit;
    logic      load;
    logic      last_name;
    t_out_word emit_word;

    assign can_emit  = !r_out_valid || i_out_ready;
    assign last_name = ((CNT_W'(r_pos) + CNT_W'(1)) == r_count);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid && can_emit && i_q_cmd.is_flush) begin
                    n_state = (i_q_count == '0) ? BK_CLOSE : BK_NAME;
                end
            end
            BK_NAME: begin
                if (can_emit && last_name) begin
                    n_state = BK_CLOSE;
                end
            end
            BK_CLOSE: begin
                if (can_emit) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        emit      = 1'b0;
        load      = 1'b0;
        o_pop     = 1'b0;
        emit_word = '0;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid && can_emit) begin
                    emit  = 1'b1;
                    o_pop = 1'b1;
                    if (i_q_cmd.is_flush) begin
                        load      = 1'b1;
                        emit_word = '{byte_out: BYTE_SPACE, last_of_run: 1'b0};
                    end else begin
                        emit_word = '{byte_out: i_q_cmd.code, last_of_run: 1'b1};
                    end
                end
            end
            BK_NAME: begin
                emit      = can_emit;
                emit_word = '{byte_out: petscii_conv(r_buf[r_pos]), last_of_run: 1'b0};
            end
            BK_CLOSE: begin
                emit      = can_emit;
                emit_word = '{byte_out: r_tail, last_of_run: 1'b1};
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word <= emit_word;
        end
        if (load) begin
            r_tail  <= i_q_cmd.code;
            r_count <= i_q_count;
            r_pos   <= '0;
            for (int k = 0; k < MAX_NAME_LEN; k++) begin
                r_buf[k] <= i_q_buf[8*k +: 8];
            end
        end else if ((r_state == BK_NAME) && can_emit) begin
            r_pos <= r_pos + IDX_W'(1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire
